@@ rtl/ste_pkg.sv @@
// ----------------------------------------------------------------------------
// ste_pkg
// Shared command codes and the per-cell control bundle of the sorted table.
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

  // command codes carried in the mode field
  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_DEL_VAL = 3'd1;
  localparam logic [2:0] MODE_DEL_POS = 3'd2;
  localparam logic [2:0] MODE_FIND    = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;

  // broadcast to every cell; at most one flag is set in a cycle
  typedef struct packed {
    logic ins;      // open a gap at the insert point and write the key
    logic del_val;  // close the gap at the first key not below the operand
    logic del_pos;  // close the gap at the addressed slot
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/ste_cell.sv @@
// ----------------------------------------------------------------------------
// ste_cell
// One slot of the sorted table: holds a key, compares it against the
// broadcast operand and takes a neighbor's key when the table shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_cell
  import ste_pkg::*;
#(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire cell_cmd_t            cmd,
  input  wire logic [KEY_WIDTH-1:0] key_bcast,
  input  wire logic                 valid,
  input  wire logic                 at_or_after_slot,
  input  wire logic                 left_lt,
  input  wire logic [KEY_WIDTH-1:0] left_key,
  input  wire logic [KEY_WIDTH-1:0] right_key,
  output logic [KEY_WIDTH-1:0]      key,
  output logic                      lt,
  output logic                      eq
);

  logic [KEY_WIDTH-1:0] key_next;
  logic                 shift_left;

  // compare against the broadcast key
  assign lt = valid && (key < key_bcast);
  assign eq = (key == key_bcast);

  // a removal pulls the right neighbor into this slot
  assign shift_left = (cmd.del_val && !lt) || (cmd.del_pos && at_or_after_slot);

  // next key: keep, take the new key, take from the left or from the right
  always_comb begin
    key_next = key;
    if (cmd.ins) begin
      if (!lt) begin
        key_next = left_lt ? key_bcast : left_key;
      end
    end else if (shift_left) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

`default_nettype wire

@@ rtl/sorted_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_table_engine_unit
// Sorted key table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: mode, key_in,
//   slot_in. Output channel (out_valid/out_ready) returns one result beat per
//   command: ok, key_out, place, fill.
//   Every cell compares its key with the operand in the same cycle; the
//   result is registered and appears in the cycle after the input beat is
//   taken. Throughput is one command per cycle while the receiver takes results;
//   the figure is set by the single compare-and-shift step across the cell
//   row, which updates all slots at the clock edge that takes the beat.
//   in_ready is high while the output register is empty or being drained, so
//   a new beat is taken in the same cycle the waiting result leaves.
//   When the receiver stalls, the result is held and at most one further
//   command waits at the input.
//   Reset (rst, synchronous) empties the table and drops any pending result;
//   key storage is not cleared, as slots at or above the fill count are
//   never read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_engine_unit
  import ste_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [31:0] key_in,
  input  wire logic [4:0]  slot_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [31:0]      key_out,
  output logic [5:0]       place,
  output logic [4:0]       fill
);

  localparam int HW = $clog2(CAPACITY + 1);
  localparam int SW = (HW > 5) ? HW : 5;

  logic                 accept;
  logic [HW-1:0]        held;
  logic [HW-1:0]        held_next;
  logic [KEY_WIDTH-1:0] key_op;
  logic [63:0]          key_in_wide;
  logic [SW-1:0]        slot_ext;
  logic [SW-1:0]        held_ext;
  logic                 slot_ok;
  logic                 full;
  cell_cmd_t            cmd;

  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]  cell_lt;
  logic [CAPACITY-1:0]  cell_eq;
  logic [CAPACITY-1:0]  cell_valid;
  logic [CAPACITY-1:0]  cell_after;
  logic [CAPACITY-1:0]  cell_first;
  logic [CAPACITY-1:0]  cell_sel;

  logic [HW-1:0]        lower_idx;
  logic                 found;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [63:0]          rd_key_wide;
  logic [5:0]           place_pos;

  logic                 res_ok;
  logic [31:0]          res_key;
  logic [5:0]           res_place;

  // handshake: output register parts the two sides
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // operand formatting
  assign key_in_wide = {32'b0, key_in};
  assign key_op      = key_in_wide[KEY_WIDTH-1:0];
  assign slot_ext    = SW'(slot_in);
  assign held_ext    = SW'(held);
  assign slot_ok     = (slot_ext != '0) && (slot_ext <= held_ext);
  assign full        = (held == HW'(CAPACITY));

  // per-cell position flags
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_flags
      assign cell_valid[gi] = (held > HW'(gi));
      assign cell_after[gi] = (SW'(gi + 1) >= slot_ext);
      assign cell_sel[gi]   = slot_ok && (SW'(gi + 1) == slot_ext);
      if (gi == 0) begin : g_first0
        assign cell_first[gi] = !cell_lt[gi];
      end else begin : g_firstn
        assign cell_first[gi] = !cell_lt[gi] && cell_lt[gi-1];
      end
    end
  endgenerate

  // lower slot index, match test and read select
  always_comb begin
    lower_idx = (|cell_first) ? '0 : HW'(CAPACITY);
    found     = 1'b0;
    rd_key    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_first[i]) begin
        lower_idx = lower_idx | HW'(i);
      end
      found  = found | (cell_first[i] & cell_valid[i] & cell_eq[i]);
      rd_key = rd_key | (cell_sel[i] ? cell_key[i] : '0);
    end
  end

  // command decode and result formation
  always_comb begin
    cmd       = '0;
    held_next = held;
    res_ok    = 1'b0;
    res_key   = '0;
    res_place = '0;
    unique case (mode)
      MODE_INSERT: begin
        if (!full) begin
          cmd.ins   = accept;
          held_next = held + HW'(1);
          res_ok    = 1'b1;
        end
      end
      MODE_DEL_VAL: begin
        if (found) begin
          cmd.del_val = accept;
          held_next   = held - HW'(1);
          res_ok      = 1'b1;
        end
      end
      MODE_DEL_POS: begin
        if (slot_ok) begin
          cmd.del_pos = accept;
          held_next   = held - HW'(1);
          res_ok      = 1'b1;
        end
      end
      MODE_FIND: begin
        res_ok    = found;
        res_place = found ? place_pos : (6'd0 - place_pos);
      end
      MODE_READ: begin
        res_ok  = slot_ok;
        res_key = rd_key_wide[31:0];
      end
      MODE_CLEAR: begin
        held_next = '0;
        res_ok    = 1'b1;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  assign place_pos   = 6'(lower_idx) + 6'd1;
  assign rd_key_wide = 64'(rd_key);

  // row of cells
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                 left_lt_w;
      logic [KEY_WIDTH-1:0] left_key_w;
      logic [KEY_WIDTH-1:0] right_key_w;
      if (gi == 0) begin : g_left0
        assign left_lt_w  = 1'b1;
        assign left_key_w = key_op;
      end else begin : g_leftn
        assign left_lt_w  = cell_lt[gi-1];
        assign left_key_w = cell_key[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_rightl
        assign right_key_w = '0;
      end else begin : g_rightn
        assign right_key_w = cell_key[gi+1];
      end
      ste_cell #(
        .KEY_WIDTH(KEY_WIDTH)
      ) u_cell (
        .clk              (clk),
        .cmd              (cmd),
        .key_bcast        (key_op),
        .valid            (cell_valid[gi]),
        .at_or_after_slot (cell_after[gi]),
        .left_lt          (left_lt_w),
        .left_key         (left_key_w),
        .right_key        (right_key_w),
        .key              (cell_key[gi]),
        .lt               (cell_lt[gi]),
        .eq               (cell_eq[gi])
      );
    end
  endgenerate

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok      <= res_ok;
      key_out <= res_key;
      place   <= res_place;
      fill    <= 5'(held_next);
    end
  end

endmodule

`default_nettype wire
